// ===== rtl/core/br2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// br2d_pkg
// Shared types and constants for the two-decimal binary64 rounder.
// ----------------------------------------------------------------------------
package br2d_pkg;

  localparam logic [10:0] ExpAllOnes = 11'h7FF;
  localparam logic [10:0] ExpIntSpaced = 11'd1075;

  // Per-item control that rides down the pipeline
  typedef struct packed {
    logic        valid;
    logic        pass;   // output = input (NaN, inf, ulp >= 1)
    logic        zero;   // output = signed zero
    logic        sign;
    logic [63:0] raw;
  } ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/binary64_round_two_decimals_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary64_round_two_decimals_top
// Rounds a binary64 value to two decimals, ties to even, exact integer math.
// ----------------------------------------------------------------------------
// Pipeline: six register stages, the last of which is the output register.
// Throughput: one item per cycle; the whole pipe advances when the output
// register is empty or being taken, so stalls hold every stage in place.
// Reset: synchronous, clears all stage valid bits; payload is not reset.
module binary64_round_two_decimals_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // [63:0] value_bits
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata    // [63:0] rounded_bits
);

  logic           en;
  br2d_pkg::ctl_t ctl;
  logic [58:0]    q;

  // Pipeline moves whenever the last register can hand off its item
  assign en = !m_axis_tvalid || m_axis_tready;
  // no item is taken while in reset
  assign s_axis_tready = en && !rst;

  br2d_scale u_scale (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_axis_tvalid), .in_bits(s_axis_tdata),
    .ctl(ctl), .q(q)
  );

  br2d_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .ctl_in(ctl), .q(q),
    .out_valid(m_axis_tvalid), .out_bits(m_axis_tdata)
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped while stalled");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during stall");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");

endmodule
`default_nettype wire

// ===== rtl/core/br2d_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// br2d_scale
// Stages 1-2: classify, multiply by 100, round to integer cents q.
// ----------------------------------------------------------------------------
module br2d_scale (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   en,
  input  wire                   in_valid,
  input  wire  [63:0]           in_bits,
  output br2d_pkg::ctl_t        ctl,
  output logic [58:0]           q
);

  br2d_pkg::ctl_t ctl1;
  logic [59:0]    n1;
  logic [5:0]     d1;

  logic [10:0] ef;
  logic [52:0] m;
  logic [10:0] dw;
  logic        zero_c;
  logic        pass_c;

  always_comb begin
    ef = in_bits[62:52];
    m  = (ef == 11'd0) ? {1'b0, in_bits[51:0]} : {1'b1, in_bits[51:0]};
    dw = (ef == 11'd0) ? 11'd1074 : (br2d_pkg::ExpIntSpaced - ef);
    pass_c = (ef == br2d_pkg::ExpAllOnes) || (ef >= br2d_pkg::ExpIntSpaced);
    zero_c = !pass_c && (dw >= 11'd61);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else if (en) begin
      ctl1.valid <= in_valid;
    end
    if (en) begin
      ctl1.pass <= pass_c;
      ctl1.zero <= zero_c;
      ctl1.sign <= in_bits[63];
      ctl1.raw  <= in_bits;
      n1 <= ({7'd0, m} << 6) + ({7'd0, m} << 5) + ({7'd0, m} << 2);
      d1 <= dw[5:0];
    end
  end

  // round n >> d to nearest, ties to even
  logic [59:0] qs;
  logic [59:0] rmask;
  logic [59:0] rr;
  logic [59:0] half;
  logic        up;
  always_comb begin
    qs    = n1 >> d1;
    rmask = (60'd1 << d1) - 60'd1;
    rr    = n1 & rmask;
    half  = (d1 == 6'd0) ? 60'd0 : (60'd1 << (d1 - 6'd1));
    up    = (d1 != 6'd0) && ((rr > half) || ((rr == half) && qs[0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl1.valid;
    end
    if (en) begin
      ctl.pass <= ctl1.pass;
      ctl.zero <= ctl1.zero;
      ctl.sign <= ctl1.sign;
      ctl.raw  <= ctl1.raw;
      q <= qs[58:0] + {58'd0, up};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/br2d_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// br2d_div
// Stages 3-6: normalize q, divide by 100 via reciprocal, round, pack.
// ----------------------------------------------------------------------------
module br2d_div (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  br2d_pkg::ctl_t      ctl_in,
  input  wire  [58:0]         q,
  output logic                out_valid,
  output logic [63:0]         out_bits
);

  // Stage 3: leading-one position and normalizing shift
  br2d_pkg::ctl_t c3;
  logic [59:0]    sc3;
  logic [6:0]     s3;
  logic           qz3;

  logic [5:0] len;
  logic [6:0] sh;
  logic [59:0] scl;
  always_comb begin
    len = 6'd0;
    for (int i = 0; i < 59; i++) begin
      if (q[i]) len = 6'(i + 1);
    end
    sh  = 7'd59 - {1'b0, len};
    scl = {1'b0, q} << sh;
    if (scl < (60'd100 << 52)) begin
      sh  = sh + 7'd1;
      scl = {1'b0, q} << sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c3.valid <= 1'b0;
    end else if (en) begin
      c3.valid <= ctl_in.valid;
    end
    if (en) begin
      c3.pass <= ctl_in.pass; c3.zero <= ctl_in.zero;
      c3.sign <= ctl_in.sign; c3.raw  <= ctl_in.raw;
      sc3 <= scl;
      s3  <= sh;
      qz3 <= (q == 59'd0);
    end
  end

  // Stage 4: scaled / 100 = (scaled >> 2) / 25; estimate with reciprocal
  // split into partial products of at most 29 x 32 bits.
  // recip = ceil(2^64/25) approximation; corrected in stage 5.
  localparam logic [63:0] Recip = 64'h0A3D70A3D70A3D71;
  br2d_pkg::ctl_t c4;
  logic [59:0]    a4;
  logic [6:0]     s4;
  logic           qz4;
  logic [127:0]   ph4;
  logic [127:0]   pl4;
  logic [57:0]    av;
  always_comb av = sc3[59:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      c4.valid <= 1'b0;
    end else if (en) begin
      c4.valid <= c3.valid;
    end
    if (en) begin
      c4.pass <= c3.pass; c4.zero <= c3.zero;
      c4.sign <= c3.sign; c4.raw  <= c3.raw;
      a4  <= sc3;
      s4  <= s3;
      qz4 <= qz3;
      ph4 <= (({99'd0, av[57:29]} * {96'd0, Recip[63:32]}) << 32)
           + ({99'd0, av[57:29]} * {96'd0, Recip[31:0]});
      pl4 <= (({99'd0, av[28:0]} * {96'd0, Recip[63:32]}) << 32)
           + ({99'd0, av[28:0]} * {96'd0, Recip[31:0]});
    end
  end

  // Stage 5: combine, fix quotient, derive remainder
  br2d_pkg::ctl_t c5;
  logic [53:0]    mt5;
  logic [6:0]     rm5;
  logic [6:0]     s5;
  logic           qz5;
  logic [127:0]   prod;
  logic [53:0]    qe;
  logic [59:0]    rem;
  always_comb begin
    prod = (ph4 << 29) + pl4;
    qe   = prod[117:64];
    rem  = a4 - ({6'd0, qe} * 60'd100);
    if (rem[59]) begin
      qe  = qe - 54'd1;
      rem = rem + 60'd100;
    end else if (rem >= 60'd100) begin
      qe  = qe + 54'd1;
      rem = rem - 60'd100;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c5.valid <= 1'b0;
    end else if (en) begin
      c5.valid <= c4.valid;
    end
    if (en) begin
      c5.pass <= c4.pass; c5.zero <= c4.zero;
      c5.sign <= c4.sign; c5.raw  <= c4.raw;
      mt5 <= qe;
      rm5 <= rem[6:0];
      s5  <= s4;
      qz5 <= qz4;
    end
  end

  // Stage 6: round the quotient and pack
  logic [53:0] mr;
  logic [6:0]  se;
  logic [63:0] res;
  logic        up;
  always_comb begin
    up = (rm5 > 7'd50) || ((rm5 == 7'd50) && mt5[0]);
    mr = mt5 + {53'd0, up};
    se = s5;
    if (mr[53]) begin
      mr = mr >> 1;
      se = se - 7'd1;
    end
    if (c5.pass) begin
      res = c5.raw;
    end else if (c5.zero || qz5) begin
      res = {c5.sign, 63'd0};
    end else begin
      res = {c5.sign, 11'(br2d_pkg::ExpIntSpaced - {4'd0, se}), mr[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c5.valid;
    end
    if (en) begin
      out_bits <= res;
    end
  end

endmodule
`default_nettype wire
